// ----- hdl/tws_pkg.sv -----
`default_nettype none

package tws_pkg;

    localparam int CAPACITY_DEF = 256;

    // Count fields on the result channel are fixed at 9 bits.
    localparam int CNT_W = 9;

    // Operation codes carried in the kind field.
    localparam logic [2:0] KIND_PUSH   = 3'd0;
    localparam logic [2:0] KIND_POP    = 3'd1;
    localparam logic [2:0] KIND_TOP    = 3'd2;
    localparam logic [2:0] KIND_STEAL  = 3'd3;
    localparam logic [2:0] KIND_DEFRAG = 3'd4;

    // Status codes of the result channel.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NONE    = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_REFUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] level;
        logic [31:0] penalty;
        logic [31:0] handle;
        logic [7:0]  index;
    } tws_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      out_level;
        logic [31:0]      out_penalty;
        logic [31:0]      out_handle;
        logic [CNT_W-1:0] height;
        logic [CNT_W-1:0] live_count;
        logic             is_empty;
    } tws_out_t;

    // One stack slot as held in the slot memory.
    typedef struct packed {
        logic        tomb;
        logic [15:0] level;
        logic [31:0] penalty;
        logic [31:0] handle;
    } tws_slot_t;

    localparam int SLOT_W = $bits(tws_slot_t);

endpackage

`default_nettype wire

// ----- hdl/tws_ram.sv -----
`default_nettype none

module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tombstone_work_stack_core.sv -----
`default_nettype none

// Work stack with lazy deletion for a parallel search.
// Input channel s_valid/s_ready/s_data carries one operation per transfer:
// push, pop, top, steal (by slot index from the bottom) or defrag. Every
// operation returns exactly one transfer on m_valid/m_ready/m_data with a
// status, the returned entry (zero when none) and the height, live count and
// empty flag after the operation.
// Slots live in one single-port-read, single-port-write memory with
// registered read; a small sequencer drives every access, one read issued per
// step. Push, pop and top read down from the top of the stack, dropping
// tombstones until they find a live slot or an empty stack; steal reads its
// one slot unless the index is out of range, and is then refused at once;
// defrag walks every slot below the height. The block takes one operation at
// a time; s_ready is high only while the sequencer is idle. The next
// operation may start while the previous result still waits on m_ready. A
// stalled receiver holds the finished result in the sequencer until the
// output register frees up.
// Reset (aresetn low, synchronous) empties the stack; slot contents are not
// cleared, since no slot at or above the height is ever read.

module tombstone_work_stack_core
    import tws_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire tws_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output tws_out_t     m_data
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_SCAN_ISSUE = 3'd1;
    localparam logic [2:0] S_SCAN_CHK   = 3'd2;
    localparam logic [2:0] S_STEAL_CHK  = 3'd3;
    localparam logic [2:0] S_DEFRAG     = 3'd4;
    localparam logic [2:0] S_DONE       = 3'd5;

    logic [2:0]    state_reg,   state_next;
    tws_in_t       op_reg,      op_next;
    logic [CW-1:0] height_reg,  height_next;
    logic [CW-1:0] live_reg,    live_next;
    logic [CW-1:0] rd_ptr_reg,  rd_ptr_next;
    logic [CW-1:0] wr_ptr_reg,  wr_ptr_next;
    logic          pend_reg,    pend_next;
    tws_out_t      res_reg,     res_next;
    tws_out_t      m_data_reg,  m_data_next;
    logic          m_valid_reg, m_valid_next;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    tws_slot_t     ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    tws_slot_t     ram_rd_data;
    logic [CW-1:0] top_idx;

    tws_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(CAPACITY)
    ) u_slots (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign top_idx = height_reg - CW'(1);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        height_next  = height_reg;
        live_next    = live_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        pend_next    = pend_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = top_idx[AW-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = top_idx[AW-1:0];

        // Drop the result once the receiver takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next  = s_data;
                    res_next = '0;
                    case (s_data.kind)
                        KIND_PUSH, KIND_POP, KIND_TOP: begin
                            state_next = S_SCAN_ISSUE;
                        end
                        KIND_STEAL: begin
                            if (CMPW'(s_data.index) < CMPW'(height_reg)) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(s_data.index);
                                state_next  = S_STEAL_CHK;
                            end else begin
                                res_next.status = STAT_REFUSED;
                                state_next      = S_DONE;
                            end
                        end
                        KIND_DEFRAG: begin
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            pend_next   = 1'b0;
                            state_next  = S_DEFRAG;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN_ISSUE: begin
                if (height_reg == '0) begin
                    // Empty stack: push lands in slot zero, pop and top fail.
                    if (op_reg.kind == KIND_PUSH) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = '{tomb: 1'b0, level: op_reg.level,
                                        penalty: op_reg.penalty,
                                        handle: op_reg.handle};
                        height_next = CW'(1);
                        live_next   = live_reg + CW'(1);
                    end else begin
                        res_next.status = STAT_NONE;
                    end
                    state_next = S_DONE;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                if (ram_rd_data.tomb) begin
                    // Drop the tombstone and look at the next slot down.
                    height_next = top_idx;
                    state_next  = S_SCAN_ISSUE;
                end else begin
                    if (op_reg.kind == KIND_PUSH) begin
                        if (height_reg >= CW'(CAPACITY)) begin
                            res_next.status = STAT_FULL;
                        end else begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = height_reg[AW-1:0];
                            ram_wr_data = '{tomb: 1'b0, level: op_reg.level,
                                            penalty: op_reg.penalty,
                                            handle: op_reg.handle};
                            height_next = height_reg + CW'(1);
                            live_next   = live_reg + CW'(1);
                        end
                    end else begin
                        res_next.out_level   = ram_rd_data.level;
                        res_next.out_penalty = ram_rd_data.penalty;
                        res_next.out_handle  = ram_rd_data.handle;
                        if (op_reg.kind == KIND_POP) begin
                            height_next = top_idx;
                            if (live_reg != '0) begin
                                live_next = live_reg - CW'(1);
                            end
                        end
                    end
                    state_next = S_DONE;
                end
            end

            S_STEAL_CHK: begin
                if (ram_rd_data.tomb) begin
                    res_next.status = STAT_REFUSED;
                end else begin
                    res_next.out_level   = ram_rd_data.level;
                    res_next.out_penalty = ram_rd_data.penalty;
                    res_next.out_handle  = ram_rd_data.handle;
                    ram_wr_en        = 1'b1;
                    ram_wr_addr      = AW'(op_reg.index);
                    ram_wr_data.tomb = 1'b1;
                    if (live_reg != '0) begin
                        live_next = live_reg - CW'(1);
                    end
                end
                state_next = S_DONE;
            end

            S_DEFRAG: begin
                // Move the slot read last cycle down to the write pointer unless it is a tombstone.
                if (pend_reg && !ram_rd_data.tomb) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = wr_ptr_reg[AW-1:0];
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                end
                if (rd_ptr_reg < height_reg) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_ptr_reg[AW-1:0];
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        height_next = wr_ptr_reg;
                        state_next  = S_DONE;
                    end
                end
            end

            S_DONE: begin
                // Hold the result until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_data_next            = res_reg;
                    m_data_next.height     = CNT_W'(height_reg);
                    m_data_next.live_count = CNT_W'(live_reg);
                    m_data_next.is_empty   = (live_reg == '0);
                    m_valid_next           = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            height_reg  <= '0;
            live_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            height_reg  <= height_next;
            live_reg    <= live_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
    import tws_pkg::*;
();

    localparam int CAP            = CAPACITY_DEF;
    localparam int IDLE_PCT       = 35;     // share of cycles each side sits out
    localparam int HOLDOFF_CYCLES = 300;    // long receiver stall, well past block depth
    localparam int WATCHDOG_LIMIT = 5000;   // well past the worst legal gap plus a stall
    localparam int RANDOM_ITEMS   = 80;
    localparam int PRESSURE_ITEMS = 30;
    localparam int STEADY_ITEMS   = 50;
    localparam int DRAIN_STEALS   = 40;
    localparam int PRINT_LIMIT    = 40;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tws_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tws_out_t m_data;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tombstone_work_stack_core #(
        .CAPACITY (CAP)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    tws_in_t     pending_ops[$];    // operations waiting for the driver
    tws_out_t    results_due[$];    // predicted results, oldest first
    logic        s_took        = 1'b0;  // last rising edge moved an input transfer
    logic        steady        = 1'b0;  // suppress random idling on both sides
    int unsigned holdoffs_asked = 0;
    int unsigned holdoffs_done  = 0;
    int unsigned holdoff_left   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned mismatches     = 0;
    int unsigned results_seen   = 0;
    int unsigned ops_sent       = 0;    // operations the block acts on
    int unsigned kind_hits[8]   = '{default: 0};
    int unsigned status_hits[4] = '{default: 0};
    int unsigned peak_depth     = 0;

    // Shadow copy of the stack. Slot contents start out zero here; the block
    // leaves them undefined, but nothing below the height is read unwritten.
    logic        slot_dead [CAP] = '{default: 1'b0};
    logic [15:0] slot_lvl  [CAP] = '{default: '0};
    logic [31:0] slot_pen  [CAP] = '{default: '0};
    logic [31:0] slot_hdl  [CAP] = '{default: '0};
    int unsigned depth_now = 0;     // slots in use, tombstones included
    int unsigned live_now  = 0;

    // ------------------------------------------------------------------
    // Stack predictor
    // ------------------------------------------------------------------
    function automatic void wipe_slot(int unsigned at);
        slot_dead[at] = 1'b0;
        slot_lvl[at]  = '0;
        slot_pen[at]  = '0;
        slot_hdl[at]  = '0;
    endfunction

    // Drop every tombstone sitting on top of the stack.
    function automatic void shed_top_tombstones();
        while (depth_now > 0 && slot_dead[depth_now - 1]) begin
            wipe_slot(depth_now - 1);
            depth_now--;
        end
    endfunction

    // Apply one operation to the shadow stack and return its result.
    function automatic tws_out_t stack_apply(tws_in_t op);
        tws_out_t    r;
        int unsigned at;
        int unsigned wr;
        r = '0;
        r.status = STAT_OK;
        case (op.kind)
            KIND_PUSH: begin
                shed_top_tombstones();
                if (depth_now >= CAP) begin
                    r.status = STAT_FULL;
                end else begin
                    slot_dead[depth_now] = 1'b0;
                    slot_lvl[depth_now]  = op.level;
                    slot_pen[depth_now]  = op.penalty;
                    slot_hdl[depth_now]  = op.handle;
                    depth_now++;
                    live_now++;
                end
            end
            KIND_POP, KIND_TOP: begin
                shed_top_tombstones();
                if (depth_now == 0) begin
                    r.status = STAT_NONE;
                end else begin
                    at = depth_now - 1;
                    r.out_level   = slot_lvl[at];
                    r.out_penalty = slot_pen[at];
                    r.out_handle  = slot_hdl[at];
                    if (op.kind == KIND_POP) begin
                        wipe_slot(at);
                        depth_now--;
                        if (live_now > 0) live_now--;
                    end
                end
            end
            KIND_STEAL: begin
                // Steal leaves the height alone; the slot becomes a tombstone.
                if (op.index < depth_now && !slot_dead[op.index]) begin
                    r.out_level   = slot_lvl[op.index];
                    r.out_penalty = slot_pen[op.index];
                    r.out_handle  = slot_hdl[op.index];
                    wipe_slot(op.index);
                    slot_dead[op.index] = 1'b1;
                    if (live_now > 0) live_now--;
                end else begin
                    r.status = STAT_REFUSED;
                end
            end
            KIND_DEFRAG: begin
                // Slide live entries down in order, clear what is left above.
                wr = 0;
                for (int unsigned rd = 0; rd < depth_now; rd++) begin
                    if (!slot_dead[rd]) begin
                        if (wr != rd) begin
                            slot_lvl[wr]  = slot_lvl[rd];
                            slot_pen[wr]  = slot_pen[rd];
                            slot_hdl[wr]  = slot_hdl[rd];
                            slot_dead[wr] = 1'b0;
                        end
                        wr++;
                    end
                end
                for (int unsigned rd = wr; rd < depth_now; rd++) wipe_slot(rd);
                depth_now = wr;
            end
            default: ;  // unused kinds leave everything as is
        endcase
        r.height     = CNT_W'(depth_now);
        r.live_count = CNT_W'(live_now);
        r.is_empty   = (live_now == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic compare_result(tws_out_t got, tws_out_t want);
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.out_level !== want.out_level)
            report_mismatch($sformatf("out_level %0h, expected %0h",
                                      got.out_level, want.out_level));
        if (got.out_penalty !== want.out_penalty)
            report_mismatch($sformatf("out_penalty %0h, expected %0h",
                                      got.out_penalty, want.out_penalty));
        if (got.out_handle !== want.out_handle)
            report_mismatch($sformatf("out_handle %0h, expected %0h",
                                      got.out_handle, want.out_handle));
        if (got.height !== want.height)
            report_mismatch($sformatf("height %0d, expected %0d", got.height, want.height));
        if (got.live_count !== want.live_count)
            report_mismatch($sformatf("live_count %0d, expected %0d",
                                      got.live_count, want.live_count));
        if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, expected %0b",
                                      got.is_empty, want.is_empty));
    endtask

    // Rising edge: take output transfers first, then predict the input
    // transfer, then feed the watchdog.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                status_hits[m_data.status]++;
                if (results_due.size() == 0)
                    report_mismatch("result transfer with no operation outstanding");
                else
                    compare_result(m_data, results_due.pop_front());
            end
            s_took <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                kind_hits[s_data.kind]++;
                results_due.push_back(stack_apply(s_data));
                if (depth_now > peak_depth) peak_depth = depth_now;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: present the next pending operation at the falling edge, hold
    // it until the transfer happens, and idle at random in between.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (pending_ops.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                s_data  <= pending_ops.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request that
    // is counted down here.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left != 0) begin
            m_ready      <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoffs_done < holdoffs_asked) begin
            m_ready       <= 1'b0;
            holdoffs_done <= holdoffs_done + 1;
            holdoff_left  <= HOLDOFF_CYCLES;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic tws_in_t make_op(logic [2:0] kind, logic [15:0] level,
                                        logic [31:0] penalty, logic [31:0] handle,
                                        logic [7:0] index);
        tws_in_t op;
        op.kind    = kind;
        op.level   = level;
        op.penalty = penalty;
        op.handle  = handle;
        op.index   = index;
        return op;
    endfunction

    // Random push payload; index bits stay random too.
    function automatic tws_in_t random_push();
        return make_op(KIND_PUSH, 16'($urandom), $urandom, $urandom, 8'($urandom));
    endfunction

    // Mixed operation; steals mostly aim inside the current height.
    function automatic tws_in_t random_op();
        tws_in_t     op;
        int unsigned roll;
        op   = random_push();
        roll = $urandom_range(99);
        if (roll < 35)       op.kind = KIND_PUSH;
        else if (roll < 50)  op.kind = KIND_POP;
        else if (roll < 60)  op.kind = KIND_TOP;
        else if (roll < 85)  op.kind = KIND_STEAL;
        else if (roll < 92)  op.kind = KIND_DEFRAG;
        else                 op.kind = KIND_DEFRAG + 3'($urandom_range(1, 3));
        if (op.kind == KIND_STEAL && depth_now > 0 && $urandom_range(99) < 80)
            op.index = 8'($urandom_range(depth_now - 1));
        return op;
    endfunction

    // Queue one operation once the driver has taken the previous one, so
    // that generation sees a nearly current shadow stack.
    task automatic send(tws_in_t op);
        while (pending_ops.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        pending_ops.push_back(op);
        if (op.kind <= KIND_DEFRAG) ops_sent++;
    endtask

    // Pause the sender until every outstanding result has come back.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_ops.size() != 0 || s_valid || results_due.size() != 0);
    endtask

    initial begin
        int unsigned goal;
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        @(posedge aclk);
        #1;

        // Directed: empty-stack refusals, field extremes, tombstone handling.
        send(make_op(KIND_POP,    '0, '0, '0, '0));            // nothing to return
        send(make_op(KIND_TOP,    '0, '0, '0, '0));
        send(make_op(KIND_STEAL,  '0, '0, '0, '0));            // nothing to steal
        send(make_op(KIND_DEFRAG, '0, '0, '0, '0));            // defrag of empty stack
        send(make_op(KIND_PUSH,   '0, '0, '0, '0));
        send(make_op(KIND_PUSH,   '1, '1, '1, '1));
        send(random_push());
        send(random_push());
        send(make_op(KIND_TOP,    '0, '0, '0, '0));
        send(make_op(KIND_STEAL,  '0, '0, '0, 8'd1));          // mid-stack steal
        send(make_op(KIND_STEAL,  '0, '0, '0, 8'd1));          // already a tombstone
        send(make_op(KIND_STEAL,  '0, '0, '0, '1));            // beyond the height
        send(make_op(KIND_STEAL,  '0, '0, '0, 8'd3));          // tombstone on top
        send(make_op(KIND_DEFRAG + 3'd1, '1, '1, '1, '1));     // unused kinds
        send(make_op(KIND_DEFRAG + 3'd2, '0, '0, '0, '0));
        send(make_op(KIND_DEFRAG + 3'd3, '1, '1, '1, '1));
        send(make_op(KIND_TOP,    '0, '0, '0, '0));            // skips top tombstone
        send(make_op(KIND_DEFRAG, '0, '0, '0, '0));            // squeezes out slot 1
        send(random_push());
        send(make_op(KIND_STEAL,  '0, '0, '0, 8'd2));
        send(make_op(KIND_STEAL,  '0, '0, '0, 8'd1));
        send(make_op(KIND_POP,    '0, '0, '0, '0));            // drops two tombstones
        send(make_op(KIND_POP,    '0, '0, '0, '0));
        send(make_op(KIND_STEAL,  '0, '0, '0, '0));
        wait_drained();

        // Random mix with idling on both sides.
        goal = ops_sent + RANDOM_ITEMS;
        while (ops_sent < goal) send(random_op());

        // Stall the receiver for a long stretch while the sender keeps offering operations.
        steady = 1'b1;
        holdoffs_asked++;
        goal = ops_sent + PRESSURE_ITEMS;
        while (ops_sent < goal) send(random_op());
        wait_drained();

        // Back-to-back stretch with no idling.
        goal = ops_sent + STEADY_ITEMS;
        while (ops_sent < goal) send(random_op());
        steady = 1'b0;
        wait_drained();

        // Fill to capacity and push against a full stack.
        while (depth_now < CAP) send(random_push());
        repeat (2) send(random_push());
        send(make_op(KIND_STEAL, '0, '0, '0, '1));             // top slot at full height
        send(make_op(KIND_STEAL, '0, '0, '0, '1));             // now a tombstone
        send(random_push());                                    // reclaims the top slot
        send(make_op(KIND_STEAL, '0, '0, '0, 8'($urandom_range(1, CAP - 2))));
        send(random_push());                                    // hole is not on top
        send(make_op(KIND_TOP,    '0, '0, '0, '0));
        send(make_op(KIND_DEFRAG, '0, '0, '0, '0));            // full-height walk
        wait_drained();
        while (depth_now < CAP) send(random_push());
        wait_drained();

        // Tombstone the upper part, then let one pop walk over all of it.
        for (int unsigned i = 0; i < DRAIN_STEALS; i++)
            send(make_op(KIND_STEAL, '0, '0, '0, 8'(CAP - 1 - i)));
        send(make_op(KIND_STEAL, '0, '0, '0, '0));             // bottom slot
        send(make_op(KIND_POP,    '0, '0, '0, '0));
        send(make_op(KIND_DEFRAG, '0, '0, '0, '0));
        wait_drained();

        // Finish with a random tail.
        goal = ops_sent + 40;
        while (ops_sent < goal) send(random_op());

        wait_drained();
        repeat (20) @(posedge aclk);
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));

        $display("covered %0d operations: push %0d, pop %0d, top %0d, steal %0d, defrag %0d,"
                 , ops_sent, kind_hits[KIND_PUSH], kind_hits[KIND_POP], kind_hits[KIND_TOP],
                 kind_hits[KIND_STEAL], kind_hits[KIND_DEFRAG]);
        $display("  %0d ignored kinds; statuses ok %0d none %0d full %0d refused %0d;",
                 kind_hits[5] + kind_hits[6] + kind_hits[7], status_hits[STAT_OK],
                 status_hits[STAT_NONE], status_hits[STAT_FULL], status_hits[STAT_REFUSED]);
        $display("  peak height %0d", peak_depth);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tws_pkg.sv
hdl/tws_ram.sv
hdl/tombstone_work_stack_core.sv
sim/tb_top.sv
